@@ rtl/mcl_pkg.sv @@
// ----------------------------------------------------------------------------
// mcl_pkg
// Types, codes and character helpers shared by the lexer and its token queue.
// ----------------------------------------------------------------------------
package mcl_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = 2;
	localparam int CNT_BITS   = 3;
	localparam int NUM_KW     = 5;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_ASSIGN = 3'd3,
		MODE_BANG   = 3'd4,
		MODE_GT     = 3'd5,
		MODE_LT     = 3'd6
	} mode_t;

	typedef enum logic [4:0] {
		K_INT       = 5'd0,
		K_IF        = 5'd1,
		K_ELSE      = 5'd2,
		K_WHILE     = 5'd3,
		K_RETURN    = 5'd4,
		K_IDENT     = 5'd5,
		K_NUMBER    = 5'd6,
		K_ASSIGN    = 5'd7,
		K_PLUS      = 5'd8,
		K_MINUS     = 5'd9,
		K_EQ        = 5'd10,
		K_NE        = 5'd11,
		K_LT        = 5'd12,
		K_LE        = 5'd13,
		K_GT        = 5'd14,
		K_GE        = 5'd15,
		K_LPAREN    = 5'd16,
		K_RPAREN    = 5'd17,
		K_LBRACE    = 5'd18,
		K_RBRACE    = 5'd19,
		K_SEMICOLON = 5'd20,
		K_ILLEGAL   = 5'd21
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [5:0]  length;
		logic        sat;
		logic [7:0]  bad;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic v;
		tok_t t;
	} cand_t;

	localparam logic [4:0] ALL_CANDIDATES = 5'h1F;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] kw_len(logic [2:0] k);
		logic [7:0] r;
		unique case (k)
			3'd0:    r = 8'd3;
			3'd1:    r = 8'd2;
			3'd2:    r = 8'd4;
			3'd3:    r = 8'd5;
			3'd4:    r = 8'd6;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] i);
		logic [7:0] r;
		r = 8'd0;
		case (k)
			3'd0: case (i)
				3'd0: r = "i";
				3'd1: r = "n";
				3'd2: r = "t";
				default: r = 8'd0;
			endcase
			3'd1: case (i)
				3'd0: r = "i";
				3'd1: r = "f";
				default: r = 8'd0;
			endcase
			3'd2: case (i)
				3'd0: r = "e";
				3'd1: r = "l";
				3'd2: r = "s";
				3'd3: r = "e";
				default: r = 8'd0;
			endcase
			3'd3: case (i)
				3'd0: r = "w";
				3'd1: r = "h";
				3'd2: r = "i";
				3'd3: r = "l";
				3'd4: r = "e";
				default: r = 8'd0;
			endcase
			3'd4: case (i)
				3'd0: r = "r";
				3'd1: r = "e";
				3'd2: r = "t";
				3'd3: r = "u";
				3'd4: r = "r";
				3'd5: r = "n";
				default: r = 8'd0;
			endcase
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// bit k survives when keyword k has character c at offset idx
	function automatic logic [4:0] kw_mask(logic [7:0] c, logic [7:0] idx);
		logic [4:0] m;
		for (int k = 0; k < NUM_KW; k++) begin
			m[k] = (idx < kw_len(3'(k))) && (kw_char(3'(k), idx[2:0]) == c);
		end
		return m;
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		kind_t r;
		case (c)
			"+":     r = K_PLUS;
			"-":     r = K_MINUS;
			"(":     r = K_LPAREN;
			")":     r = K_RPAREN;
			"{":     r = K_LBRACE;
			"}":     r = K_RBRACE;
			";":     r = K_SEMICOLON;
			default: r = K_ILLEGAL;
		endcase
		return r;
	endfunction

	// token left pending by a mode, if any
	function automatic cand_t flush_tok(mode_t m, logic [7:0] len, logic [15:0] start,
			logic ovf, logic [4:0] cands);
		cand_t r;
		r.v        = 1'b1;
		r.t.kind   = K_IDENT;
		r.t.start  = start;
		r.t.length = 6'd1;
		r.t.sat    = 1'b0;
		r.t.bad    = 8'd0;
		r.t.last   = 1'b0;
		case (m)
			MODE_IDENT: begin
				r.t.length = len[5:0];
				r.t.sat    = ovf;
				if (!ovf) begin
					for (int k = 0; k < NUM_KW; k++) begin
						if (cands[k] && len == kw_len(3'(k)))
							r.t.kind = kind_t'(5'(k));
					end
				end
			end
			MODE_NUMBER: begin
				r.t.kind   = K_NUMBER;
				r.t.length = len[5:0];
				r.t.sat    = ovf;
			end
			MODE_ASSIGN: r.t.kind = K_ASSIGN;
			MODE_BANG: begin
				r.t.kind = K_ILLEGAL;
				r.t.bad  = "!";
			end
			MODE_GT: r.t.kind = K_GT;
			MODE_LT: r.t.kind = K_LT;
			default: r.v = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mcl_tok_fifo.sv @@
// ----------------------------------------------------------------------------
// mcl_tok_fifo
// Small token queue: takes up to two tokens per cycle, gives one per cycle while head_pop is high.
// ----------------------------------------------------------------------------
module mcl_tok_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_cnt,
	input  mcl_pkg::tok_t push_tok0,
	input  mcl_pkg::tok_t push_tok1,
	output logic         room2,
	output logic         head_valid,
	input  logic         head_pop,
	output mcl_pkg::tok_t head_tok
);

	mcl_pkg::tok_t mem_q [mcl_pkg::FIFO_DEPTH];
	logic [mcl_pkg::PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [mcl_pkg::CNT_BITS-1:0] count_q;
	logic pop;

	assign pop        = head_valid && head_pop;
	assign head_valid = count_q != '0;
	assign room2      = count_q <= mcl_pkg::CNT_BITS'(mcl_pkg::FIFO_DEPTH - 2);
	assign head_tok   = mem_q[rd_ptr_q];
	assign wr_ptr1    = wr_ptr_q + mcl_pkg::PTR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mcl_pkg::PTR_BITS'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + mcl_pkg::PTR_BITS'(1);
			count_q <= count_q + mcl_pkg::CNT_BITS'(push_cnt) - mcl_pkg::CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_tok0;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr1] <= push_tok1;
	end

endmodule

@@ rtl/mini_c_lexer.sv @@
// ----------------------------------------------------------------------------
// mini_c_lexer
// Streaming lexer for a small C subset, one character per beat.
// ----------------------------------------------------------------------------
// A token enters the 4-entry token queue on the beat that ends it and leaves
// from its head. Throughput: one character per cycle while in_ready is high; the
// tokens of a two-token beat drain through the single-token output port.
// Reset: asynchronous, lexer idle at offset 0, token queue empty.
module mini_c_lexer #(
	parameter int MAX_TOKEN_LEN = 63,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [5:0]  token_length,
	output logic        length_saturated,
	output logic [7:0]  illegal_char,
	output logic        last_of_run
);

	localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

	mcl_pkg::mode_t mode_q, mode_n;
	logic [LEN_BITS-1:0]      run_len_q, run_len_n;
	logic [15:0]              run_start_q, run_start_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [4:0]               cands_q, cands_n;
	logic                     ovf_q, ovf_n;

	logic        accept, brk, strt;
	logic [31:0] pos_ext;
	logic [15:0] pos16;
	logic [7:0]  c;
	mcl_pkg::cand_t a, b, e, r0, r1;
	logic [1:0]  push_cnt;
	mcl_pkg::tok_t head_tok;

	assign accept  = in_valid && in_ready;
	assign c       = char_code;
	assign pos_ext = 32'(pos_q);
	assign pos16   = pos_ext[15:0];

	always_comb begin
		mode_n      = mode_q;
		run_len_n   = run_len_q;
		run_start_n = run_start_q;
		cands_n     = cands_q;
		ovf_n       = ovf_q;
		brk         = 1'b0;
		strt        = 1'b0;
		a           = '0;
		b           = '0;

		case (mode_q) inside
			mcl_pkg::MODE_IDENT: begin
				if (mcl_pkg::is_letter(c) || mcl_pkg::is_digit(c)) begin
					cands_n = cands_q & mcl_pkg::kw_mask(c, 8'(run_len_q));
					if (run_len_q < LEN_BITS'(MAX_TOKEN_LEN))
						run_len_n = run_len_q + LEN_BITS'(1);
					else
						ovf_n = 1'b1;
				end else begin
					brk = 1'b1;
				end
			end
			mcl_pkg::MODE_NUMBER: begin
				if (mcl_pkg::is_digit(c)) begin
					if (run_len_q < LEN_BITS'(MAX_TOKEN_LEN))
						run_len_n = run_len_q + LEN_BITS'(1);
					else
						ovf_n = 1'b1;
				end else begin
					brk = 1'b1;
				end
			end
			mcl_pkg::MODE_ASSIGN, mcl_pkg::MODE_BANG, mcl_pkg::MODE_GT,
			mcl_pkg::MODE_LT: begin
				if (c == "=") begin
					a.v        = 1'b1;
					a.t.start  = run_start_q;
					a.t.length = 6'd2;
					case (mode_q)
						mcl_pkg::MODE_ASSIGN: a.t.kind = mcl_pkg::K_EQ;
						mcl_pkg::MODE_BANG:   a.t.kind = mcl_pkg::K_NE;
						mcl_pkg::MODE_GT:     a.t.kind = mcl_pkg::K_GE;
						default:              a.t.kind = mcl_pkg::K_LE;
					endcase
					mode_n = mcl_pkg::MODE_IDLE;
				end else begin
					brk = 1'b1;
				end
			end
			default: strt = 1'b1;
		endcase

		if (brk) begin
			a    = mcl_pkg::flush_tok(mode_q, 8'(run_len_q), run_start_q, ovf_q, cands_q);
			strt = 1'b1;
		end

		if (strt) begin
			mode_n = mcl_pkg::MODE_IDLE;
			if (!mcl_pkg::is_space(c)) begin
				if (mcl_pkg::is_letter(c) || mcl_pkg::is_digit(c) || c == "=" ||
						c == "!" || c == ">" || c == "<") begin
					run_start_n = pos16;
					run_len_n   = LEN_BITS'(1);
					ovf_n       = 1'b0;
					cands_n     = mcl_pkg::ALL_CANDIDATES;
					if (mcl_pkg::is_letter(c)) begin
						mode_n  = mcl_pkg::MODE_IDENT;
						cands_n = mcl_pkg::ALL_CANDIDATES & mcl_pkg::kw_mask(c, 8'd0);
					end else if (mcl_pkg::is_digit(c))
						mode_n = mcl_pkg::MODE_NUMBER;
					else if (c == "=")
						mode_n = mcl_pkg::MODE_ASSIGN;
					else if (c == "!")
						mode_n = mcl_pkg::MODE_BANG;
					else if (c == ">")
						mode_n = mcl_pkg::MODE_GT;
					else
						mode_n = mcl_pkg::MODE_LT;
				end else begin
					b.v        = 1'b1;
					b.t.kind   = mcl_pkg::single_kind(c);
					b.t.start  = pos16;
					b.t.length = 6'd1;
					b.t.bad    = (b.t.kind == mcl_pkg::K_ILLEGAL) ? c : 8'd0;
				end
			end
		end

		// end of input flushes whatever the character left pending
		e = mcl_pkg::flush_tok(mode_n, 8'(run_len_n), run_start_n, ovf_n, cands_n);
		if (end_of_input) begin
			mode_n = mcl_pkg::MODE_IDLE;
			pos_n  = '0;
		end else begin
			e.v   = 1'b0;
			pos_n = pos_q + POSITION_BITS'(1);
		end

		// pack the valid candidates in order; at most two are ever valid
		r0 = a.v ? a : (b.v ? b : e);
		if (a.v)
			r1 = b.v ? b : e;
		else if (b.v)
			r1 = e;
		else
			r1 = '0;
		if (r1.v)
			r1.t.last = 1'b1;
		else
			r0.t.last = 1'b1;
		push_cnt = accept ? (2'(r0.v) + 2'(r1.v)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= mcl_pkg::MODE_IDLE;
			run_len_q   <= '0;
			run_start_q <= '0;
			pos_q       <= '0;
			cands_q     <= mcl_pkg::ALL_CANDIDATES;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_n;
			run_len_q   <= run_len_n;
			run_start_q <= run_start_n;
			pos_q       <= pos_n;
			cands_q     <= cands_n;
			ovf_q       <= ovf_n;
		end
	end

	mcl_tok_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_tok0  (r0.t),
		.push_tok1  (r1.t),
		.room2      (in_ready),
		.head_valid (out_valid),
		.head_pop   (out_ready),
		.head_tok   (head_tok)
	);

	assign token_kind       = head_tok.kind;
	assign token_start      = head_tok.start;
	assign token_length     = head_tok.length;
	assign length_saturated = head_tok.sat;
	assign illegal_char     = head_tok.bad;
	assign last_of_run      = head_tok.last;

endmodule
